### rtl/core/ptic_pkg.sv
// Package for the prefix trie block: sizes, operation codes, the controller
// state type and the layout of the two node memories. No dependencies.
package ptic_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int FREE_W        = NODE_W + 1;
  localparam int OP_W          = 2;
  localparam int LETTER_W      = 5;
  localparam int COUNT_W       = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

  localparam logic [LETTER_W-1:0] LETTER_MAX = LETTER_W'(ALPHABET_SIZE - 1);
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [FREE_W-1:0]   FREE_LIMIT = FREE_W'(NODE_COUNT);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK,
    ST_NODE
  } ptic_state_t;

  // One row of child links: one link per letter, zero meaning no child.
  typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] link_row_t;

  // Per-node information kept beside the links.
  typedef struct packed {
    logic               mark;
    logic [COUNT_W-1:0] pass;
  } node_info_t;

endpackage

### rtl/core/prefix_trie_insert_count.sv
// Prefix trie with insert, exact lookup and prefix count, one letter per transfer.
// Depends on ptic_pkg for sizes, operation codes, the state type and memory layouts.
//
// The trie is held in two synchronous memories of NODE_COUNT rows each: a
// link memory whose row holds one child pointer per letter, and an info
// memory whose row holds the word-end mark and the saturating pass count.
// After reset the block clears both memories, one row a cycle, and holds
// in_ready low meanwhile. A letter then passes through the accept (idle) and
// link states, and also through the node state if it enters a node during
// an insert or is the last letter of its word. The node state is needed
// because the pass count and mark of the node entered have to be read from
// the info memory and written back. An insert letter that finds the table
// full, or that follows a failure earlier in its word, enters no node and
// skips the node state unless it is the last letter. The link memory read
// is registered: the next letter's row address is the child pointer chosen
// for this letter. An item with the unused operation code is taken and has
// no effect. Each word yields exactly one result transfer, on its last
// letter; the result sits in an output register, and the block stalls only
// when a second result is ready while the first has not yet been taken.
module prefix_trie_insert_count (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ptic_pkg::OP_W-1:0]      in_operation,
  input  logic [ptic_pkg::LETTER_W-1:0]  in_letter,
  input  logic                           in_last_letter,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic                           out_word_found,
  output logic [ptic_pkg::COUNT_W-1:0]   out_prefix_count
);
  import ptic_pkg::*;

  // Memories.
  link_row_t  link_mem [NODE_COUNT];
  node_info_t info_mem [NODE_COUNT];

  link_row_t  link_rdata_r;
  node_info_t info_rdata_r;

  logic              link_re, link_we;
  logic [NODE_W-1:0] link_waddr;
  link_row_t         link_wdata;
  logic              info_re, info_we;
  logic [NODE_W-1:0] info_raddr, info_waddr;
  node_info_t        info_wdata;

  // Control state.
  ptic_state_t       state_r, state_nxt;
  logic [NODE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [FREE_W-1:0] next_free_r, next_free_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic              failed_r, failed_nxt;
  logic              overflow_r, overflow_nxt;
  logic              inc_r, inc_nxt;

  // The letter being worked on.
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic                last_r, last_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_found_r, out_found_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic              in_xfer;
  logic [NODE_W-1:0] child;
  node_info_t        info_upd;
  logic              set_mark;
  logic              advance;

  assign in_ready         = (state_r == ST_IDLE);
  assign in_xfer          = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_word_found   = out_found_r;
  assign out_prefix_count = out_count_r;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata_r <= link_mem[cursor_r];
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    if (info_re) begin
      info_rdata_r <= info_mem[info_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= FREE_W'(1);
      cursor_r    <= '0;
      failed_r    <= 1'b0;
      overflow_r  <= 1'b0;
      inc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      cursor_r    <= cursor_nxt;
      failed_r    <= failed_nxt;
      overflow_r  <= overflow_nxt;
      inc_r       <= inc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    letter_r     <= letter_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // The child pointer for the current letter, and the info row updated for
  // the node the cursor has just entered.
  assign child    = link_rdata_r[letter_r];
  assign set_mark = last_r && (op_r == OP_INSERT) && !failed_r;
  always_comb begin
    info_upd      = info_rdata_r;
    info_upd.mark = info_rdata_r.mark | set_mark;
    if (inc_r && (info_rdata_r.pass != COUNT_MAX)) begin
      info_upd.pass = info_rdata_r.pass + COUNT_W'(1);
    end
  end

  // A last letter may leave the node stage only when the result register is free.
  assign advance = !last_r || !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    next_free_nxt  = next_free_r;
    cursor_nxt     = cursor_r;
    failed_nxt     = failed_r;
    overflow_nxt   = overflow_r;
    inc_nxt        = inc_r;
    op_nxt         = op_r;
    letter_nxt     = letter_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;

    link_re    = 1'b0;
    link_we    = 1'b0;
    link_waddr = cursor_r;
    link_wdata = link_rdata_r;
    info_re    = 1'b0;
    info_we    = 1'b0;
    info_raddr = cursor_r;
    info_waddr = cursor_r;
    info_wdata = info_upd;

    case (state_r)
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_cnt_r;
        link_wdata = '0;
        info_we    = 1'b1;
        info_waddr = clr_cnt_r;
        info_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + NODE_W'(1);
        if (clr_cnt_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // The unused operation code is taken and dropped.
        if (in_xfer && (in_operation <= OP_PREFIX)) begin
          op_nxt     = in_operation;
          letter_nxt = (in_letter > LETTER_MAX) ? LETTER_MAX : in_letter;
          last_nxt   = in_last_letter;
          link_re    = 1'b1;
          state_nxt  = ST_LINK;
        end
      end

      ST_LINK: begin
        inc_nxt = 1'b0;
        if (!failed_r) begin
          if (op_r == OP_INSERT) begin
            if (child == '0) begin
              if (next_free_r < FREE_LIMIT) begin
                // Hang a fresh node on this letter; its rows were cleared.
                link_we                = 1'b1;
                link_wdata[letter_r]   = next_free_r[NODE_W-1:0];
                next_free_nxt          = next_free_r + FREE_W'(1);
                cursor_nxt             = next_free_r[NODE_W-1:0];
                inc_nxt                = 1'b1;
              end else begin
                failed_nxt   = 1'b1;
                overflow_nxt = 1'b1;
              end
            end else begin
              cursor_nxt = child;
              inc_nxt    = 1'b1;
            end
          end else if (child == '0) begin
            failed_nxt = 1'b1;
          end else begin
            cursor_nxt = child;
          end
        end
        info_re    = 1'b1;
        info_raddr = cursor_nxt;
        if (last_r || inc_nxt) begin
          state_nxt = ST_NODE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_NODE: begin
        if (advance) begin
          info_we   = inc_r || set_mark;
          state_nxt = ST_IDLE;
          if (last_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = (op_r == OP_INSERT) && overflow_r;
            out_found_nxt  = (op_r == OP_LOOKUP) && !failed_r && info_rdata_r.mark;
            out_count_nxt  = ((op_r == OP_PREFIX) && !failed_r) ? info_rdata_r.pass : '0;
            cursor_nxt     = '0;
            failed_nxt     = 1'b0;
            overflow_nxt   = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

### tb/trie_checker.sv
// Checker for the prefix trie block: watches both channels, predicts each answer
// and compares it with the result transfer. Depends on ptic_pkg for sizes and codes.
module trie_checker
  import ptic_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_last_letter,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_status,
  input  logic                out_word_found,
  input  logic [COUNT_W-1:0]  out_prefix_count,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic               status;
    logic               word_found;
    logic [COUNT_W-1:0] prefix_count;
  } trie_answer_t;

  // Shadow copy of the trie.
  logic [NODE_W-1:0]  shadow_links [NODE_COUNT*ALPHABET_SIZE];
  logic               shadow_mark  [NODE_COUNT];
  logic [COUNT_W-1:0] shadow_pass  [NODE_COUNT];
  logic [FREE_W-1:0]  free_node;
  logic [NODE_W-1:0]  walk_node;
  logic               walk_failed;
  logic               walk_overflow;

  trie_answer_t expected_answers [$];
  int           mismatch_total  = 0;
  int           answers_waiting = 0;

  assign fail_count = mismatch_total;
  assign pending    = answers_waiting;

  // Moves the cursor by one letter and queues the answer on the last letter.
  task automatic walk_letter(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input logic last);
    logic [LETTER_W-1:0] clamped;
    int unsigned         slot;
    logic [NODE_W-1:0]   child;
    trie_answer_t        ans;
    if (op == OP_INSERT || op == OP_LOOKUP || op == OP_PREFIX) begin
      clamped = (ltr > LETTER_MAX) ? LETTER_MAX : ltr;
      if (!walk_failed) begin
        slot  = walk_node * ALPHABET_SIZE + clamped;
        child = shadow_links[slot];
        if (op == OP_INSERT) begin
          if (child == '0) begin
            if (free_node < FREE_LIMIT) begin
              child              = free_node[NODE_W-1:0];
              free_node          = free_node + 1'b1;
              shadow_links[slot] = child;
            end else begin
              walk_failed   = 1'b1;
              walk_overflow = 1'b1;
            end
          end
          if (!walk_failed) begin
            walk_node = child;
            if (shadow_pass[child] != COUNT_MAX) shadow_pass[child] = shadow_pass[child] + 1'b1;
          end
        end else if (child == '0) begin
          walk_failed = 1'b1;
        end else begin
          walk_node = child;
        end
      end
      if (last) begin
        ans = '0;
        if (op == OP_INSERT) begin
          if (!walk_failed) shadow_mark[walk_node] = 1'b1;
          ans.status = walk_overflow;
        end else if (op == OP_LOOKUP) begin
          if (!walk_failed) ans.word_found = shadow_mark[walk_node];
        end else begin
          if (!walk_failed) ans.prefix_count = shadow_pass[walk_node];
        end
        expected_answers.push_back(ans);
        walk_node     = '0;
        walk_failed   = 1'b0;
        walk_overflow = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    trie_answer_t got;
    trie_answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT * ALPHABET_SIZE; i++) shadow_links[i] = '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        shadow_mark[i] = 1'b0;
        shadow_pass[i] = '0;
      end
      free_node     = FREE_W'(1);
      walk_node     = '0;
      walk_failed   = 1'b0;
      walk_overflow = 1'b0;
      expected_answers.delete();
    end else begin
      if (in_valid && in_ready) walk_letter(in_operation, in_letter, in_last_letter);
      if (out_valid && out_ready) begin
        got = {out_status, out_word_found, out_prefix_count};
        if (expected_answers.size() == 0) begin
          $display("%0t: result with none expected: status %0d found %0d count %0d",
                   $time, got.status, got.word_found, got.prefix_count);
          mismatch_total++;
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            $display("%0t: expected status %0d found %0d count %0d, got %0d %0d %0d",
                     $time, want.status, want.word_found, want.prefix_count,
                     got.status, got.word_found, got.prefix_count);
            mismatch_total++;
          end
        end
      end
    end
    answers_waiting <= expected_answers.size();
  end

endmodule

### tb/tb_top.sv
// Top of the prefix trie testbench: clock, reset, stimulus and verdict.
// Depends on ptic_pkg, the block prefix_trie_insert_count and trie_checker.
module tb_top;
  import ptic_pkg::*;

  // The unused operation code; the block must take such a transfer and ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Longest run of cycles with no transfer on either channel that we tolerate.
  // The clearing pass after reset alone is far longer than what a normal letter
  // costs with the worst sender gap and receiver stall.
  localparam int WATCHDOG_LIMIT = 5 * NODE_COUNT;

  localparam int RANDOM_ITEMS = 1280;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation;
  logic [LETTER_W-1:0] in_letter;
  logic                in_last_letter;
  logic                out_valid;
  logic                out_ready;
  logic                out_status;
  logic                out_word_found;
  logic [COUNT_W-1:0]  out_prefix_count;

  int fail_count;
  int pending;
  int letters_sent;
  int quiet_cycles;
  bit gaps_on;

  prefix_trie_insert_count u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_letter        (in_letter),
    .in_last_letter   (in_last_letter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_word_found   (out_word_found),
    .out_prefix_count (out_prefix_count)
  );

  trie_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_letter        (in_letter),
    .in_last_letter   (in_last_letter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_word_found   (out_word_found),
    .out_prefix_count (out_prefix_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops ready at random, about eleven times in a hundred, while
  // gaps are enabled, and stays ready throughout the stretches where they are not.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (gaps_on) begin
      out_ready <= ($urandom_range(0, 99) >= 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAIL prefix_trie_insert_count");
    $finish;
  end

  // Offers one letter and returns at the falling edge after its transfer. Valid
  // is left high, so back-to-back letters keep it high without a dip. A random
  // gap now and then lands on every phase of the block's work.
  task automatic send_letter(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_letter      <= ltr;
    in_last_letter <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    letters_sent++;
    @(negedge clk);
  endtask

  // Sends a whole word. Narrow words draw from four letters so that paths are
  // shared and queries hit; mixed words give each letter an operation of its own.
  task automatic send_word(input logic [OP_W-1:0] op, input int len, input bit narrow,
                           input bit mixed);
    logic [OP_W-1:0]     this_op;
    logic [LETTER_W-1:0] ltr;
    for (int i = 0; i < len; i++) begin
      this_op = mixed ? OP_W'($urandom_range(0, 2)) : op;
      ltr     = narrow ? LETTER_W'($urandom_range(0, 3)) : LETTER_W'($urandom_range(0, 31));
      send_letter(this_op, ltr, (i == len - 1));
    end
  endtask

  // A mix of well-formed words with random content and a minority of noise:
  // mixed-operation words, transfers with the unused code and stray letters.
  task automatic random_traffic(input int item_goal, input bit with_pause);
    int  pick;
    int  start;
    bit  paused;
    start  = letters_sent;
    paused = 1'b0;
    while (letters_sent - start < item_goal) begin
      // Once, the sender holds off until every answer owed has been delivered.
      if (with_pause && !paused && letters_sent - start >= item_goal / 3) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        paused = 1'b1;
      end
      // A stretch in the middle with neither side idling.
      gaps_on = !(with_pause && letters_sent - start >= item_goal / 2 &&
                  letters_sent - start < (item_goal * 3) / 4);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_word(OP_W'($urandom_range(0, 2)), $urandom_range(1, 6),
                  ($urandom_range(0, 99) < 80), 1'b0);
      end else if (pick < 92) begin
        send_word(OP_INSERT, $urandom_range(2, 5), 1'b1, 1'b1);
      end else if (pick < 96) begin
        send_letter(OP_UNUSED, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else begin
        send_letter(OP_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)), 1'b1);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_INSERT;
    in_letter      = '0;
    in_last_letter = 1'b0;
    letters_sent   = 0;
    gaps_on        = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words. The first insert builds "ab"; lookups then test an exact
    // hit and a prefix that is not itself a word, and prefix count reads back.
    send_letter(OP_INSERT, 5'd0, 1'b0);
    send_letter(OP_INSERT, 5'd1, 1'b1);
    send_letter(OP_LOOKUP, 5'd0, 1'b0);
    send_letter(OP_LOOKUP, 5'd1, 1'b1);
    send_letter(OP_LOOKUP, 5'd0, 1'b1);
    send_letter(OP_PREFIX, 5'd0, 1'b1);
    // Letters past the end of the alphabet saturate onto the last letter, so
    // these two inserts land on the same node.
    send_letter(OP_INSERT, 5'd25, 1'b1);
    send_letter(OP_INSERT, 5'd31, 1'b1);
    send_letter(OP_PREFIX, 5'd31, 1'b1);
    send_letter(OP_LOOKUP, 5'd28, 1'b1);
    // Queries along a missing path answer zero.
    send_letter(OP_LOOKUP, 5'd2, 1'b1);
    send_letter(OP_PREFIX, 5'd2, 1'b0);
    send_letter(OP_PREFIX, 5'd3, 1'b1);
    // The unused operation is swallowed, also in the middle of a word.
    send_letter(OP_UNUSED, 5'd31, 1'b1);
    send_letter(OP_PREFIX, 5'd0, 1'b0);
    send_letter(OP_UNUSED, 5'd7, 1'b0);
    send_letter(OP_PREFIX, 5'd1, 1'b1);
    // Mixed operations in one word: the last letter decides the answer.
    send_letter(OP_INSERT, 5'd2, 1'b0);
    send_letter(OP_LOOKUP, 5'd3, 1'b1);
    send_letter(OP_LOOKUP, 5'd0, 1'b0);
    send_letter(OP_PREFIX, 5'd1, 1'b1);
    send_letter(OP_PREFIX, 5'd0, 1'b0);
    send_letter(OP_LOOKUP, 5'd1, 1'b1);

    random_traffic(RANDOM_ITEMS, 1'b1);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS prefix_trie_insert_count");
    end else begin
      $display("FAIL prefix_trie_insert_count");
    end
    $finish;
  end

endmodule
